// ----- hw/rtl/tacho_velocity_observer_assert.svh -----
// Assertion macros used by the checker file of the tacho velocity observer.
// Depends on nothing; the using scope provides clk and rst_n.
`ifndef TACHO_VELOCITY_OBSERVER_ASSERT_SVH
`define TACHO_VELOCITY_OBSERVER_ASSERT_SVH

// Same-cycle implication, disabled in reset
`define TVO_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tvo assertion failed");

// Next-cycle implication, disabled in reset
`define TVO_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tvo assertion failed");

`endif

// ----- hw/rtl/tvo_pkg.sv -----
// Package of the tacho velocity observer: job types, register codes,
// fixed-point coefficients and saturation helper. No dependencies.
`timescale 1ns / 1ps
package tvo_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;
  localparam int DIV_BITS        = 48;
  localparam int LAST_STEP       = 8;

  // Configuration register indexes
  localparam logic [1:0] CFG_NUMERATOR = 2'd0;
  localparam logic [1:0] CFG_LIMIT     = 2'd1;
  localparam logic [1:0] CFG_TIMEOUT   = 2'd2;

  localparam logic [31:0] NUMERATOR_RST = 32'd226194671;
  localparam logic [14:0] LIMIT_RST     = 15'd2000;
  localparam logic [15:0] TIMEOUT_RST   = 16'd50;

  // Q16.24 (40-bit) and Q1.24 (25-bit) model coefficients
  localparam logic signed [39:0] GAIN_K0 = 40'sd1651045827;
  localparam logic signed [39:0] GAIN_K1 = 40'sd66639102;
  localparam logic signed [39:0] GAIN_K2 = -40'sd9563013;
  localparam logic signed [39:0] GAIN_K3 = 40'sd479828;
  localparam logic signed [24:0] LAG_T2     = 25'sd292796;
  localparam logic signed [24:0] BLEND_MEAS = 25'sd671089;
  localparam logic signed [24:0] BLEND_PRED = 25'sd16106127;
  localparam logic signed [24:0] BIAS_ERR   = 25'sd33554;
  localparam logic signed [24:0] BIAS_KEEP  = 25'sd16743662;

  // One classified tick, front to back
  typedef struct packed {
    logic        cap;
    logic        clear;
    logic [31:0] period;
    logic [15:0] volt;
    logic [15:0] count;
  } tvo_job_t;

  typedef struct packed {
    logic [31:0] numerator;
    logic [14:0] limit;
  } tvo_back_cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
    logic signed [31:0] r;
    if (x > 66'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (x < -66'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/tvo_front.sv -----
// Front end: accepts ticks, computes tacho period, timeout and capture count.
// Depends on tvo_pkg.
`timescale 1ns / 1ps
module tvo_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic             in_capture_event,
  input  logic [31:0]      in_count_now,
  input  logic [31:0]      in_capture_rise,
  input  logic [31:0]      in_capture_fall,
  input  logic signed [16:0] in_drive_voltage,
  input  logic [15:0]      timeout_ticks,
  output logic             push,
  output tvo_pkg::tvo_job_t job
);
  import tvo_pkg::*;

  logic [15:0] ticks_r, ticks_nxt;
  logic [15:0] count_r, count_nxt;
  logic [31:0] age_rise, age_fall;
  logic [15:0] ticks_inc;

  assign push     = in_valid && !in_stall;
  assign age_rise = in_count_now - in_capture_rise;
  assign age_fall = in_count_now - in_capture_fall;
  assign ticks_inc = (ticks_r != 16'hffff) ? ticks_r + 16'd1 : ticks_r;

  // Classify the tick
  always_comb begin
    ticks_nxt  = ticks_r;
    count_nxt  = count_r;
    job.cap    = in_capture_event;
    job.clear  = 1'b0;
    job.period = (age_rise < age_fall) ? in_capture_rise - in_capture_fall
                                       : in_capture_fall - in_capture_rise;
    job.volt   = in_drive_voltage[16] ? 16'd0 : in_drive_voltage[15:0];
    if (push) begin
      if (in_capture_event) begin
        ticks_nxt = '0;
        count_nxt = count_r + 16'd1;
      end else if (ticks_inc > timeout_ticks) begin
        ticks_nxt = '0;
        job.clear = 1'b1;
      end else begin
        ticks_nxt = ticks_inc;
      end
    end
    job.count = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= '0;
      count_r <= '0;
    end else begin
      ticks_r <= ticks_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

// ----- hw/rtl/tvo_fifo.sv -----
// Short job queue between front and back ends.
// Depends on tvo_pkg.
`timescale 1ns / 1ps
module tvo_fifo #(
  parameter int DEPTH = tvo_pkg::QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tvo_pkg::tvo_job_t push_job,
  input  logic              pop,
  output tvo_pkg::tvo_job_t pop_job,
  output logic              full,
  output logic              empty
);
  import tvo_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tvo_job_t          mem_r [DEPTH];
  logic [PW-1:0]     wr_r, rd_r;
  logic [CW-1:0]     cnt_r;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign pop_job = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= (wr_r == PW'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
      end
      if (pop) begin
        rd_r <= (rd_r == PW'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

// ----- hw/rtl/tvo_back.sv -----
// Back end: radix-2 speed divider, shared multiplier sequencer for the lag
// model and blend, and the result register. Depends on tvo_pkg.
`timescale 1ns / 1ps
module tvo_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tvo_pkg::tvo_back_cfg_t cfg,
  input  logic                  q_empty,
  input  tvo_pkg::tvo_job_t     q_job,
  output logic                  q_pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    out_velocity_estimate,
  output logic signed [31:0]    out_measured_velocity,
  output logic signed [31:0]    out_bias_estimate,
  output logic [15:0]           out_capture_count
);
  import tvo_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_CHK  = 6'b000100,
    S_MUL  = 6'b001000,
    S_ACC  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t               state_r, state_nxt;
  tvo_job_t             job_r, job_nxt;
  logic [31:0]          rem_r, rem_nxt;
  logic [47:0]          quo_r, quo_nxt;
  logic [5:0]           dcnt_r, dcnt_nxt;
  logic [3:0]           step_r, step_nxt;
  logic signed [39:0]   a_r, a_nxt;
  logic signed [39:0]   pred_r, pred_nxt;
  logic signed [65:0]   acc_r, acc_nxt;
  logic signed [64:0]   prod_r, prod_nxt;
  logic signed [31:0]   held_r, held_nxt, fused_r, fused_nxt, bias_r, bias_nxt;
  logic                 ov_r, ov_nxt;
  logic signed [31:0]   oe_r, om_r, ob_r;
  logic [15:0]          oc_r;
  logic                 load_out;

  logic [32:0]          trial;
  logic signed [39:0]   op_a, held_x, bias_x, fused_x;
  logic signed [24:0]   op_b, volt_x;
  logic signed [64:0]   sh12, sh20, sh24;
  logic signed [65:0]   sum_x;

  assign held_x  = {{8{held_r[31]}}, held_r};
  assign bias_x  = {{8{bias_r[31]}}, bias_r};
  assign fused_x = {{8{fused_r[31]}}, fused_r};
  assign volt_x  = {9'd0, job_r.volt};
  assign trial   = {rem_r, quo_r[47]};
  assign sh12    = prod_r >>> 12;
  assign sh20    = prod_r >>> 20;
  assign sh24    = prod_r >>> 24;
  assign sum_x   = (acc_r + $signed({prod_r[64], prod_r})) >>> 24;

  // Multiplier operand select per step
  always_comb begin
    op_a = a_r;
    op_b = volt_x;
    case (step_r)
      4'd0: op_a = GAIN_K3;
      4'd4: op_b = LAG_T2;
      4'd5: begin op_a = held_x;          op_b = BLEND_MEAS; end
      4'd6: begin op_a = pred_r + bias_x; op_b = BLEND_PRED; end
      4'd7: begin op_a = held_x - pred_r; op_b = BIAS_ERR;   end
      4'd8: begin op_a = bias_x;          op_b = BIAS_KEEP;  end
      default: ;
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    dcnt_nxt  = dcnt_r;
    step_nxt  = step_r;
    a_nxt     = a_r;
    pred_nxt  = pred_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    held_nxt  = held_r;
    fused_nxt = fused_r;
    bias_nxt  = bias_r;
    q_pop     = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop    = 1'b1;
          job_nxt  = q_job;
          step_nxt = '0;
          rem_nxt  = '0;
          dcnt_nxt = '0;
          quo_nxt  = {cfg.numerator, 16'd0};
          if (q_job.cap && q_job.period != '0) begin
            state_nxt = S_DIV;
          end else begin
            if (q_job.clear) begin
              held_nxt = '0;
            end
            state_nxt = S_MUL;
          end
        end
      end
      S_DIV: begin
        if (trial >= {1'b0, job_r.period}) begin
          rem_nxt = 32'(trial - {1'b0, job_r.period});
          quo_nxt = {quo_r[46:0], 1'b1};
        end else begin
          rem_nxt = trial[31:0];
          quo_nxt = {quo_r[46:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 6'd1;
        if (dcnt_r == 6'(DIV_BITS - 1)) begin
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (quo_r < {17'd0, cfg.limit, 16'd0}) begin
          held_nxt = quo_r[31:0];
        end
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt  = op_a * op_b;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        case (step_r)
          4'd0: a_nxt = GAIN_K2 + sh12[39:0];
          4'd1: a_nxt = GAIN_K1 + sh12[39:0];
          4'd2: a_nxt = GAIN_K0 + sh12[39:0];
          4'd3: a_nxt = sh20[39:0] - fused_x;
          4'd4: pred_nxt = fused_x + sh24[39:0];
          4'd6: fused_nxt = sat32(sum_x);
          4'd8: bias_nxt = sat32(sum_x);
          default: acc_nxt = {prod_r[64], prod_r};
        endcase
        step_nxt  = step_r + 4'd1;
        state_nxt = (step_r == 4'(LAST_STEP)) ? S_OUT : S_MUL;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ov_nxt = load_out | (ov_r & out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      held_r  <= '0;
      fused_r <= '0;
      bias_r  <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      held_r  <= held_nxt;
      fused_r <= fused_nxt;
      bias_r  <= bias_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dcnt_r <= dcnt_nxt;
    step_r <= step_nxt;
    a_r    <= a_nxt;
    pred_r <= pred_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
    if (load_out) begin
      oe_r <= fused_r;
      om_r <= held_r;
      ob_r <= bias_r;
      oc_r <= job_r.count;
    end
  end

  assign out_valid             = ov_r;
  assign out_velocity_estimate = oe_r;
  assign out_measured_velocity = om_r;
  assign out_bias_estimate     = ob_r;
  assign out_capture_count     = oc_r;

endmodule

// ----- hw/rtl/tacho_velocity_observer.sv -----
// Top level of the tacho velocity observer: configuration registers, front
// end, job queue and back end. Depends on tvo_pkg, tvo_front, tvo_fifo, tvo_back.
//
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall | capture event, counts, voltage
//  out_    | output    | out_valid/out_stall | estimate, measurement, bias, count
//  cfg_    | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// A tick with a usable capture runs the 48-step radix-2 divider, then 9
// multiply/accumulate pairs on one shared multiplier; other ticks only the pairs.
// The front end accepts into a queue (2 deep by default) while the back end works.
// Synchronous active-low reset; no clearing pass. A stalled result holds
// the back end in its final state; cfg_ready is always high.
`timescale 1ns / 1ps
module tacho_velocity_observer #(
  parameter int QUEUE_DEPTH = tvo_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_capture_event,
  input  logic [31:0]        in_count_now,
  input  logic [31:0]        in_capture_rise,
  input  logic [31:0]        in_capture_fall,
  input  logic signed [16:0] in_drive_voltage,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_velocity_estimate,
  output logic signed [31:0] out_measured_velocity,
  output logic signed [31:0] out_bias_estimate,
  output logic [15:0]        out_capture_count,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);
  import tvo_pkg::*;

  logic [31:0]   numerator_r;
  logic [14:0]   limit_r;
  logic [15:0]   timeout_r;
  tvo_back_cfg_t back_cfg;
  tvo_job_t      f_job, q_job;
  logic          push, pop, full, empty;

  assign cfg_ready = 1'b1;
  assign in_stall  = full;
  assign back_cfg.numerator = numerator_r;
  assign back_cfg.limit     = limit_r;

  // Configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      numerator_r <= NUMERATOR_RST;
      limit_r     <= LIMIT_RST;
      timeout_r   <= TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_NUMERATOR: numerator_r <= cfg_data;
        CFG_LIMIT:     limit_r     <= cfg_data[14:0];
        CFG_TIMEOUT:   timeout_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  tvo_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_capture_event, .in_count_now,
    .in_capture_rise, .in_capture_fall, .in_drive_voltage,
    .timeout_ticks(timeout_r), .push, .job(f_job)
  );

  tvo_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk, .rst_n, .push, .push_job(f_job), .pop, .pop_job(q_job), .full, .empty
  );

  tvo_back u_back (
    .clk, .rst_n, .cfg(back_cfg), .q_empty(empty), .q_job, .q_pop(pop),
    .out_valid, .out_stall, .out_velocity_estimate, .out_measured_velocity,
    .out_bias_estimate, .out_capture_count
  );

endmodule

// ----- hw/rtl/tvo_checker.sv -----
// Port-level checker for the tacho velocity observer, bound to the top level.
// Depends on tacho_velocity_observer_assert.svh.
`timescale 1ns / 1ps
`include "tacho_velocity_observer_assert.svh"
module tvo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] out_velocity_estimate,
  input logic [31:0] out_measured_velocity,
  input logic [15:0] out_capture_count,
  input logic        cfg_valid,
  input logic        cfg_ready
);
  // A stalled result stays and holds its payload
  `TVO_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_velocity_estimate) && $stable(out_capture_count))
  // Held tacho speed is never negative in a new result
  `TVO_ASSERT_NOW(a_meas_pos, $rose(out_valid), !out_measured_velocity[31])
  // Configuration writes are never refused
  `TVO_ASSERT_NOW(a_cfg_rdy, cfg_valid, cfg_ready)
endmodule

bind tacho_velocity_observer tvo_checker u_tvo_checker (
  .clk, .rst_n, .out_valid, .out_stall, .out_velocity_estimate,
  .out_measured_velocity, .out_capture_count, .cfg_valid, .cfg_ready
);
